>>> rtl/core/kvt_pkg.sv
// kvt_pkg: shared types, codes and defaults for the sorted key/value table
// depends on nothing; used by the interfaces, the record memory and the top level
package kvt_pkg;

  localparam int TableDepthDef = 64;
  localparam int NameBytesDef  = 8;
  localparam int MaxResults    = 64;
  localparam int ResCntW       = $clog2(MaxResults + 1);

  localparam int CmdW   = 3;
  localparam int KeyW   = 32;
  localparam int NameW  = 64;
  localparam int ValW   = 16;
  localparam int MedW   = 17;
  localparam int KindW  = 3;
  localparam int BitIdxW = $clog2(ValW);

  localparam logic [CmdW-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CmdW-1:0] CMD_KEY     = 3'd1;
  localparam logic [CmdW-1:0] CMD_VALUE   = 3'd2;
  localparam logic [CmdW-1:0] CMD_LIST    = 3'd3;
  localparam logic [CmdW-1:0] CMD_STATS   = 3'd4;

  localparam logic [KindW-1:0] KIND_RECORD = 3'd0;
  localparam logic [KindW-1:0] KIND_NONE   = 3'd1;
  localparam logic [KindW-1:0] KIND_STATS  = 3'd2;
  localparam logic [KindW-1:0] KIND_FULL   = 3'd3;
  localparam logic [KindW-1:0] KIND_EMPTY  = 3'd4;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [NameW-1:0]       name;
    logic [ValW-1:0]        value;
  } rec_t;

  // write request into the record memory
  typedef struct packed {
    logic en;
    rec_t data;
  } wr_ctl_t;

endpackage

>>> rtl/core/kvt_if.sv
// kvt_in_if and kvt_out_if: valid/ready channels for commands and results
// depends on kvt_pkg
interface kvt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [kvt_pkg::CmdW-1:0]             command;
  logic signed [kvt_pkg::KeyW-1:0]      student_id;
  logic [kvt_pkg::NameW-1:0]            name_chars;
  logic [kvt_pkg::ValW-1:0]             grade;
  modport source (output valid, command, student_id, name_chars, grade, input ready);
  modport sink   (input valid, command, student_id, name_chars, grade, output ready);
endinterface

interface kvt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [kvt_pkg::KindW-1:0]            kind;
  logic signed [kvt_pkg::KeyW-1:0]      key_out;
  logic [kvt_pkg::NameW-1:0]            name_out;
  logic [kvt_pkg::ValW-1:0]             value_out;
  logic [kvt_pkg::ValW-1:0]             maximum;
  logic [kvt_pkg::MedW-1:0]             median_times_two;
  logic [kvt_pkg::ValW-1:0]             minimum;
  logic                                 last;
  modport source (output valid, kind, key_out, name_out, value_out, maximum,
                  median_times_two, minimum, last, input ready);
  modport sink   (input valid, kind, key_out, name_out, value_out, maximum,
                  median_times_two, minimum, last, output ready);
endinterface

>>> rtl/core/kvt_mem.sv
// kvt_mem: record memory, one write port and one registered read port
// depends on kvt_pkg
module kvt_mem #(
  parameter int TABLE_DEPTH = kvt_pkg::TableDepthDef,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     rd_addr,
  output kvt_pkg::rec_t        rd_data,
  input  logic [IDX_W-1:0]     wr_addr,
  input  kvt_pkg::wr_ctl_t     wr
);

  kvt_pkg::rec_t mem [TABLE_DEPTH];
  kvt_pkg::rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/keyed_record_table_with_median.sv
// channel | dir | payload                                         | accept
// in_ch   | in  | command, student_id, name_chars, grade          | valid & ready
// out_ch  | out | kind, key_out, name_out, value_out, max/med/min, last | valid & ready
//
// one command at a time; every scan step is a read then an evaluate of one entry
// insert: scan up to the slot, shift each entry above it up one (a read then a write),
// then write the record; search/list: up to one scan step per stored entry, stalled by a full
// output; statistics: 16 radix passes, each a scan of every entry through the single read port
// of the record memory; rst_n (sync, active low) empties the table; memory contents need no clearing
// a full output register stalls the scan, the next command waits for ready in idle
module keyed_record_table_with_median #(
  parameter int TABLE_DEPTH = kvt_pkg::TableDepthDef,
  parameter int NAME_BYTES  = kvt_pkg::NameBytesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  kvt_in_if.sink     in_ch,
  kvt_out_if.source  out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [kvt_pkg::NameW-1:0] NAME_MASK =
    {kvt_pkg::NameW{1'b1}} >> (kvt_pkg::NameW - 8 * NAME_BYTES);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [kvt_pkg::ResCntW-1:0] RES_LIM = kvt_pkg::ResCntW'(kvt_pkg::MaxResults);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_EV  = 4'd2;
  localparam logic [3:0] S_SH_RD   = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_INS_PUT = 4'd5;
  localparam logic [3:0] S_SC_RD   = 4'd6;
  localparam logic [3:0] S_SC_EV   = 4'd7;
  localparam logic [3:0] S_SC_FIN  = 4'd8;
  localparam logic [3:0] S_ST_RD   = 4'd9;
  localparam logic [3:0] S_ST_EV   = 4'd10;
  localparam logic [3:0] S_ST_PASS = 4'd11;
  localparam logic [3:0] S_ST_OUT  = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [kvt_pkg::CmdW-1:0]      cmd_r, cmd_nxt;
  kvt_pkg::rec_t                 req_r, req_nxt;
  kvt_pkg::rec_t                 hold_r, hold_nxt;
  logic                          hold_vld_r, hold_vld_nxt;
  logic [kvt_pkg::ResCntW-1:0]   res_r, res_nxt;
  logic [kvt_pkg::KindW-1:0]     pend_kind_r, pend_kind_nxt;
  // radix select state for the two middle ranks
  logic [kvt_pkg::BitIdxW-1:0]   bit_r, bit_nxt;
  logic [kvt_pkg::ValW-1:0]      pfx0_r, pfx0_nxt, pfx1_r, pfx1_nxt;
  logic [CNT_W-1:0]              rk0_r, rk0_nxt, rk1_r, rk1_nxt;
  logic [CNT_W-1:0]              c0_r, c0_nxt, c1_r, c1_nxt;
  logic [kvt_pkg::ValW-1:0]      max_r, max_nxt, min_r, min_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [kvt_pkg::KindW-1:0]     o_kind_r, o_kind_nxt;
  kvt_pkg::rec_t                 o_rec_r, o_rec_nxt;
  logic [kvt_pkg::ValW-1:0]      o_max_r, o_max_nxt, o_min_r, o_min_nxt;
  logic [kvt_pkg::MedW-1:0]      o_med_r, o_med_nxt;
  logic                          o_last_r, o_last_nxt;

  logic [IDX_W-1:0]              rd_addr, wr_addr;
  kvt_pkg::rec_t                 rd_data;
  kvt_pkg::wr_ctl_t              wr;
  logic                          slot_free;
  logic [kvt_pkg::ValW-1:0]      upper_mask;
  logic [CNT_W-1:0]              idx_inc;

  kvt_mem #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign idx_inc    = idx_r + CNT_W'(1);
  assign upper_mask = {kvt_pkg::ValW{1'b1}} << ({1'b0, bit_r} + 5'd1);

  // shifting reads the entry below the one being written
  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    if (state_r == S_SH_RD) begin
      rd_addr = IDX_W'(idx_r - CNT_W'(1));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    res_nxt       = res_r;
    pend_kind_nxt = pend_kind_r;
    bit_nxt       = bit_r;
    pfx0_nxt      = pfx0_r;
    pfx1_nxt      = pfx1_r;
    rk0_nxt       = rk0_r;
    rk1_nxt       = rk1_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_kind_nxt    = o_kind_r;
    o_rec_nxt     = o_rec_r;
    o_max_nxt     = o_max_r;
    o_min_nxt     = o_min_r;
    o_med_nxt     = o_med_r;
    o_last_nxt    = o_last_r;
    wr            = '0;
    wr_addr       = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        idx_nxt      = '0;
        hold_vld_nxt = 1'b0;
        res_nxt      = '0;
        if (in_ch.valid) begin
          cmd_nxt        = in_ch.command;
          req_nxt.key    = in_ch.student_id;
          req_nxt.name   = in_ch.name_chars & NAME_MASK;
          req_nxt.value  = in_ch.grade;
          case (in_ch.command)
            kvt_pkg::CMD_INSERT: state_nxt = S_INS_RD;
            kvt_pkg::CMD_KEY, kvt_pkg::CMD_VALUE, kvt_pkg::CMD_LIST:
              state_nxt = S_SC_RD;
            kvt_pkg::CMD_STATS: begin
              if (cnt_r == '0) begin
                pend_kind_nxt = kvt_pkg::KIND_EMPTY;
                state_nxt     = S_EMIT;
              end else begin
                state_nxt = S_ST_RD;
                bit_nxt   = kvt_pkg::BitIdxW'(kvt_pkg::ValW - 1);
                pfx0_nxt  = '0;
                pfx1_nxt  = '0;
                rk0_nxt   = (cnt_r - CNT_W'(1)) >> 1;
                rk1_nxt   = cnt_r >> 1;
                c0_nxt    = '0;
                c1_nxt    = '0;
                max_nxt   = '0;
                min_nxt   = '1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_INS_RD: begin
        if (idx_r == cnt_r) begin
          // new key goes after every stored key
          if (cnt_r == DEPTH_CNT) begin
            pend_kind_nxt = kvt_pkg::KIND_FULL;
            state_nxt     = S_EMIT;
          end else begin
            rk0_nxt   = cnt_r;
            state_nxt = S_SH_RD;
            idx_nxt   = cnt_r;
          end
        end else begin
          state_nxt = S_INS_EV;
        end
      end

      S_INS_EV: begin
        if (rd_data.key == req_r.key) begin
          wr.en         = 1'b1;
          wr.data       = rd_data;
          wr.data.value = req_r.value;
          state_nxt     = S_IDLE;
        end else if (rd_data.key > req_r.key) begin
          if (cnt_r == DEPTH_CNT) begin
            pend_kind_nxt = kvt_pkg::KIND_FULL;
            state_nxt     = S_EMIT;
          end else begin
            // remember the slot in rk0_r, shift from the top down to it
            rk0_nxt   = idx_r;
            idx_nxt   = cnt_r;
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_INS_RD;
        end
      end

      S_SH_RD: begin
        if (idx_r == rk0_r || idx_r == '0) begin
          state_nxt = S_INS_PUT;
        end else begin
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        wr.en     = 1'b1;
        wr.data   = rd_data;
        idx_nxt   = idx_r - CNT_W'(1);
        state_nxt = S_SH_RD;
      end

      S_INS_PUT: begin
        wr.en     = 1'b1;
        wr.data   = req_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_IDLE;
      end

      S_SC_RD: begin
        state_nxt = (idx_r == cnt_r) ? S_SC_FIN : S_SC_EV;
      end

      S_SC_EV: begin
        if (cmd_r == kvt_pkg::CMD_KEY) begin
          if (rd_data.key == req_r.key) begin
            hold_nxt     = rd_data;
            hold_vld_nxt = 1'b1;
            state_nxt    = S_SC_FIN;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SC_RD;
          end
        end else if (cmd_r == kvt_pkg::CMD_LIST || rd_data.value == req_r.value) begin
          // the held match goes out once the next one proves it is not the last
          if (!hold_vld_r || slot_free) begin
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              o_kind_nxt    = kvt_pkg::KIND_RECORD;
              o_rec_nxt     = hold_r;
              o_max_nxt     = '0;
              o_min_nxt     = '0;
              o_med_nxt     = '0;
              o_last_nxt    = 1'b0;
            end
            hold_nxt     = rd_data;
            hold_vld_nxt = 1'b1;
            res_nxt      = res_r + kvt_pkg::ResCntW'(1);
            idx_nxt      = idx_inc;
            state_nxt    = (res_r + kvt_pkg::ResCntW'(1) == RES_LIM) ? S_SC_FIN : S_SC_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SC_RD;
        end
      end

      S_SC_FIN: begin
        if (hold_vld_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt    = kvt_pkg::KIND_RECORD;
            o_rec_nxt     = hold_r;
            o_max_nxt     = '0;
            o_min_nxt     = '0;
            o_med_nxt     = '0;
            o_last_nxt    = 1'b1;
            hold_vld_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else if (cmd_r == kvt_pkg::CMD_LIST) begin
          state_nxt = S_IDLE;
        end else begin
          pend_kind_nxt = kvt_pkg::KIND_NONE;
          state_nxt     = S_EMIT;
        end
      end

      S_ST_RD: begin
        state_nxt = S_ST_EV;
      end

      S_ST_EV: begin
        if (((rd_data.value ^ pfx0_r) & upper_mask) == '0 && !rd_data.value[bit_r]) begin
          c0_nxt = c0_r + CNT_W'(1);
        end
        if (((rd_data.value ^ pfx1_r) & upper_mask) == '0 && !rd_data.value[bit_r]) begin
          c1_nxt = c1_r + CNT_W'(1);
        end
        if (rd_data.value > max_r) max_nxt = rd_data.value;
        if (rd_data.value < min_r) min_nxt = rd_data.value;
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == cnt_r) ? S_ST_PASS : S_ST_RD;
      end

      S_ST_PASS: begin
        if (rk0_r >= c0_r) begin
          pfx0_nxt[bit_r] = 1'b1;
          rk0_nxt         = rk0_r - c0_r;
        end
        if (rk1_r >= c1_r) begin
          pfx1_nxt[bit_r] = 1'b1;
          rk1_nxt         = rk1_r - c1_r;
        end
        c0_nxt  = '0;
        c1_nxt  = '0;
        idx_nxt = '0;
        if (bit_r == '0) begin
          state_nxt = S_ST_OUT;
        end else begin
          bit_nxt   = bit_r - kvt_pkg::BitIdxW'(1);
          state_nxt = S_ST_RD;
        end
      end

      S_ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kvt_pkg::KIND_STATS;
          o_rec_nxt     = '0;
          o_max_nxt     = max_r;
          o_min_nxt     = min_r;
          o_med_nxt     = {1'b0, pfx0_r} + {1'b0, pfx1_r};
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = pend_kind_r;
          o_rec_nxt     = '0;
          o_max_nxt     = '0;
          o_min_nxt     = '0;
          o_med_nxt     = '0;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    req_r       <= req_nxt;
    hold_r      <= hold_nxt;
    pend_kind_r <= pend_kind_nxt;
    bit_r       <= bit_nxt;
    pfx0_r      <= pfx0_nxt;
    pfx1_r      <= pfx1_nxt;
    rk0_r       <= rk0_nxt;
    rk1_r       <= rk1_nxt;
    c0_r        <= c0_nxt;
    c1_r        <= c1_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    o_kind_r    <= o_kind_nxt;
    o_rec_r     <= o_rec_nxt;
    o_max_r     <= o_max_nxt;
    o_min_r     <= o_min_nxt;
    o_med_r     <= o_med_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = o_kind_r;
  assign out_ch.key_out          = o_rec_r.key;
  assign out_ch.name_out         = o_rec_r.name;
  assign out_ch.value_out        = o_rec_r.value;
  assign out_ch.maximum          = o_max_r;
  assign out_ch.median_times_two = o_med_r;
  assign out_ch.minimum          = o_min_r;
  assign out_ch.last             = o_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("entry count moved by other than one");

  a_wr_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_INS_EV || state_r == S_SH_WR || state_r == S_INS_PUT))
    else $error("memory written outside an insert");

  a_hold_scan: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (state_r == S_SC_RD || state_r == S_SC_EV || state_r == S_SC_FIN))
    else $error("held match outside a scan");

endmodule
